// File: rtl/atrlc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atrlc_pkg
// Shared types, codes and keyword tables of the modem reply line classifier.
// ----------------------------------------------------------------------------
package atrlc_pkg;

    localparam int LINE_BYTES    = 128;
    localparam int PATTERN_CHARS = 16;
    localparam int WIN_CHARS     = 16;

    // input modes
    localparam logic [1:0] MODE_BYTE  = 2'd0;
    localparam logic [1:0] MODE_FLUSH = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    // verdict codes
    localparam logic [1:0] V_NONE   = 2'd0;
    localparam logic [1:0] V_OK     = 2'd1;
    localparam logic [1:0] V_ERROR  = 2'd2;
    localparam logic [1:0] V_CLOSED = 2'd3;

    // outcome codes
    localparam logic [1:0] O_WAIT    = 2'd0;
    localparam logic [1:0] O_SUCCESS = 2'd1;
    localparam logic [1:0] O_FAILURE = 2'd2;
    localparam logic [1:0] O_TIMEOUT = 2'd3;

    // register indexes
    localparam logic [2:0] REG_OK_LOW   = 3'd0;
    localparam logic [2:0] REG_OK_HIGH  = 3'd1;
    localparam logic [2:0] REG_OK_LEN   = 3'd2;
    localparam logic [2:0] REG_ERR_LOW  = 3'd3;
    localparam logic [2:0] REG_ERR_HIGH = 3'd4;
    localparam logic [2:0] REG_ERR_LEN  = 3'd5;

    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;

    // turn a string literal into a table with character 0 in bits 7:0
    function automatic logic [127:0] pack_text(input logic [127:0] s, input int n);
        logic [127:0] r;
        r = '0;
        for (int i = 0; i < 16; i++) begin
            if (i < n) r[8*i +: 8] = s[8*(n-1-i) +: 8];
        end
        return r;
    endfunction

    localparam int LEN_ERROR = 5;
    localparam int LEN_WD    = 15;
    localparam int LEN_IP    = 11;
    localparam int LEN_CL    = 6;
    localparam int LEN_CN    = 7;
    localparam int LEN_CF    = 12;
    localparam int LEN_DNS   = 8;

    localparam logic [127:0] K_ERROR = pack_text("ERROR", LEN_ERROR);
    localparam logic [127:0] K_WD    = pack_text("WIFI DISCONNECT", LEN_WD);
    localparam logic [127:0] K_IP    = pack_text("WIFI GOT IP", LEN_IP);
    localparam logic [127:0] K_CL    = pack_text("CLOSED", LEN_CL);
    localparam logic [127:0] K_CN    = pack_text("CONNECT", LEN_CN);
    localparam logic [127:0] K_CF    = pack_text("CONNECT FAIL", LEN_CF);
    localparam logic [127:0] K_DNS   = pack_text("DNS FAIL", LEN_DNS);

    // prefix match vector: bit j set when pattern chars 0..j end at this byte
    function automatic logic [WIN_CHARS-1:0] match_step(input logic [WIN_CHARS-1:0] m,
                                                        input logic [7:0] b,
                                                        input logic [127:0] pat);
        logic [WIN_CHARS-1:0] r;
        r[0] = (b == pat[7:0]);
        for (int j = 1; j < WIN_CHARS; j++) begin
            r[j] = m[j-1] && (b == pat[8*j +: 8]);
        end
        return r;
    endfunction

    typedef struct packed {
        logic accept;
        logic rd_issue;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic need_scan;
        logic n_zero;
        logic pos_last;
        logic out_busy;
    } t_status;

endpackage

// File: rtl/at_response_line_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// at_response_line_classifier
// Assembles modem reply lines and classifies each finished or flushed line.
// ----------------------------------------------------------------------------
// A byte that does not end a line, a clear or an unknown mode is taken with
// no scan. A newline or flush scans the n trimmed bytes, one a cycle, and
// registers the result once the scan has drained.
// The next word is taken in the cycle after the result is loaded;
// a result not yet taken holds the result stage and with it the input.
// Reset clears line lengths, link flags, config registers and the result valid flag.
module at_response_line_classifier #(
    parameter int LINE_BYTES = atrlc_pkg::LINE_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_verdict,
    output logic [1:0]  o_outcome,
    output logic        o_wifi_up,
    output logic        o_tcp_up,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    atrlc_pkg::t_cmd    w_cmd;
    atrlc_pkg::t_status w_status;

    // sequencer
    atrlc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // datapath
    atrlc_datapath #(.LINE_BYTES(LINE_BYTES)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mode      (i_mode),
        .i_rx_byte   (i_rx_byte),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_verdict   (o_verdict),
        .o_outcome   (o_outcome),
        .o_wifi_up   (o_wifi_up),
        .o_tcp_up    (o_tcp_up),
        .i_cmd       (w_cmd),
        .o_status    (w_status)
    );

endmodule

// File: rtl/atrlc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atrlc_ram
// Generic one write, one read port RAM with registered read data.
// ----------------------------------------------------------------------------
module atrlc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/atrlc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atrlc_ctrl
// Sequencer: takes words, runs the line scan and hands off the result.
// ----------------------------------------------------------------------------
module atrlc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  atrlc_pkg::t_status i_status,
    output atrlc_pkg::t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // next state and commands
    always_comb begin
        n_state        = r_state;
        o_cmd.accept   = 1'b0;
        o_cmd.rd_issue = 1'b0;
        o_cmd.load     = 1'b0;
        o_in_ready     = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
                if (i_in_valid && i_status.need_scan) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (i_status.n_zero) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.rd_issue = 1'b1;
                    if (i_status.pos_last) n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_DONE;
            S_DONE: begin
                if (!i_status.out_busy) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

endmodule

// File: rtl/atrlc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atrlc_datapath
// Line store, config registers, keyword matchers and result register.
// ----------------------------------------------------------------------------
module atrlc_datapath #(
    parameter int LINE_BYTES = atrlc_pkg::LINE_BYTES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [1:0]         i_mode,
    input  logic [7:0]         i_rx_byte,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [63:0]        i_cfg_data,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [1:0]         o_verdict,
    output logic [1:0]         o_outcome,
    output logic               o_wifi_up,
    output logic               o_tcp_up,
    input  atrlc_pkg::t_cmd    i_cmd,
    output atrlc_pkg::t_status o_status
);

    localparam int AW = $clog2(LINE_BYTES);
    localparam int WC = atrlc_pkg::WIN_CHARS;

    // config registers
    logic [63:0] r_ok_lo, r_ok_hi, r_err_lo, r_err_hi;
    logic [4:0]  r_ok_len, r_err_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ok_lo <= '0; r_ok_hi <= '0; r_ok_len <= '0;
            r_err_lo <= '0; r_err_hi <= '0; r_err_len <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                atrlc_pkg::REG_OK_LOW:   r_ok_lo   <= i_cfg_data;
                atrlc_pkg::REG_OK_HIGH:  r_ok_hi   <= i_cfg_data;
                atrlc_pkg::REG_OK_LEN:   r_ok_len  <= i_cfg_data[4:0];
                atrlc_pkg::REG_ERR_LOW:  r_err_lo  <= i_cfg_data;
                atrlc_pkg::REG_ERR_HIGH: r_err_hi  <= i_cfg_data;
                atrlc_pkg::REG_ERR_LEN:  r_err_len <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // pattern lengths saturated to the table size
    logic [4:0] w_ok_plen, w_err_plen;
    assign w_ok_plen  = (r_ok_len > 5'(atrlc_pkg::PATTERN_CHARS)) ?
                        5'(atrlc_pkg::PATTERN_CHARS) : r_ok_len;
    assign w_err_plen = (r_err_len > 5'(atrlc_pkg::PATTERN_CHARS)) ?
                        5'(atrlc_pkg::PATTERN_CHARS) : r_err_len;

    // line length and trimmed length bookkeeping
    logic [AW-1:0] r_len, n_len, r_trim, n_trim, r_pos;
    logic          w_we, w_crlf;

    assign w_crlf = (i_rx_byte == atrlc_pkg::CH_CR) || (i_rx_byte == atrlc_pkg::CH_LF);

    always_comb begin
        n_len  = r_len;
        n_trim = r_trim;
        w_we   = 1'b0;
        if (i_cmd.accept) begin
            case (i_mode)
                atrlc_pkg::MODE_BYTE: begin
                    if (r_len < AW'(LINE_BYTES - 1)) begin
                        w_we  = 1'b1;
                        n_len = r_len + AW'(1);
                        if (!w_crlf) n_trim = r_len + AW'(1);
                    end
                end
                atrlc_pkg::MODE_CLEAR: begin
                    n_len  = '0;
                    n_trim = '0;
                end
                default: ;
            endcase
        end
        if (i_cmd.load) begin
            n_len  = '0;
            n_trim = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_trim <= '0;
        end else begin
            r_len  <= n_len;
            r_trim <= n_trim;
        end
    end

    // line store
    logic [7:0] w_rdata;

    atrlc_ram #(.WIDTH(8), .DEPTH(LINE_BYTES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_len),
        .i_wdata (i_rx_byte),
        .i_raddr (r_pos),
        .o_rdata (w_rdata)
    );

    // scan pointer and read data valid
    logic r_dv, r_flush;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= 1'b0;
        end else begin
            r_dv <= i_cmd.rd_issue;
        end
        if (i_cmd.accept) begin
            r_pos   <= '0;
            r_flush <= (i_mode == atrlc_pkg::MODE_FLUSH);
        end else if (i_cmd.rd_issue) begin
            r_pos <= r_pos + AW'(1);
        end
    end

    // keyword matchers, one byte a cycle
    logic [WC-1:0] r_m_er, r_m_wd, r_m_ip, r_m_cl, r_m_cn, r_m_cf, r_m_dn, r_m_ep, r_m_op;
    logic [WC-1:0] n_m_er, n_m_wd, n_m_ip, n_m_cl, n_m_cn, n_m_cf, n_m_dn, n_m_ep, n_m_op;
    logic          r_h_wd, r_h_ip, r_h_cl, r_h_ep, r_h_op;

    always_comb begin
        n_m_er = atrlc_pkg::match_step(r_m_er, w_rdata, atrlc_pkg::K_ERROR);
        n_m_wd = atrlc_pkg::match_step(r_m_wd, w_rdata, atrlc_pkg::K_WD);
        n_m_ip = atrlc_pkg::match_step(r_m_ip, w_rdata, atrlc_pkg::K_IP);
        n_m_cl = atrlc_pkg::match_step(r_m_cl, w_rdata, atrlc_pkg::K_CL);
        n_m_cn = atrlc_pkg::match_step(r_m_cn, w_rdata, atrlc_pkg::K_CN);
        n_m_cf = atrlc_pkg::match_step(r_m_cf, w_rdata, atrlc_pkg::K_CF);
        n_m_dn = atrlc_pkg::match_step(r_m_dn, w_rdata, atrlc_pkg::K_DNS);
        n_m_ep = atrlc_pkg::match_step(r_m_ep, w_rdata, {r_err_hi, r_err_lo});
        n_m_op = atrlc_pkg::match_step(r_m_op, w_rdata, {r_ok_hi, r_ok_lo});
    end

    logic [3:0] w_ep_bit, w_op_bit;
    assign w_ep_bit = 4'(w_err_plen - 5'd1);
    assign w_op_bit = 4'(w_ok_plen - 5'd1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_m_er <= '0; r_m_wd <= '0; r_m_ip <= '0; r_m_cl <= '0; r_m_cn <= '0;
            r_m_cf <= '0; r_m_dn <= '0; r_m_ep <= '0; r_m_op <= '0;
            r_h_wd <= 1'b0; r_h_ip <= 1'b0; r_h_cl <= 1'b0;
            r_h_ep <= 1'b0; r_h_op <= 1'b0;
        end else if (r_dv) begin
            r_m_er <= n_m_er; r_m_wd <= n_m_wd; r_m_ip <= n_m_ip; r_m_cl <= n_m_cl;
            r_m_cn <= n_m_cn; r_m_cf <= n_m_cf; r_m_dn <= n_m_dn;
            r_m_ep <= n_m_ep; r_m_op <= n_m_op;
            r_h_wd <= r_h_wd | n_m_wd[atrlc_pkg::LEN_WD-1];
            r_h_ip <= r_h_ip | n_m_ip[atrlc_pkg::LEN_IP-1];
            r_h_cl <= r_h_cl | n_m_cl[atrlc_pkg::LEN_CL-1];
            r_h_ep <= r_h_ep | ((w_err_plen != 5'd0) && n_m_ep[w_ep_bit]);
            r_h_op <= r_h_op | ((w_ok_plen != 5'd0) && n_m_op[w_op_bit]);
        end
    end

    // exact matches: a full match ending at the last byte of a line that long
    logic w_ex_er, w_ex_cn, w_ex_cf, w_ex_dn;
    assign w_ex_er = (r_trim == AW'(atrlc_pkg::LEN_ERROR)) && r_m_er[atrlc_pkg::LEN_ERROR-1];
    assign w_ex_cn = (r_trim == AW'(atrlc_pkg::LEN_CN)) && r_m_cn[atrlc_pkg::LEN_CN-1];
    assign w_ex_cf = (r_trim == AW'(atrlc_pkg::LEN_CF)) && r_m_cf[atrlc_pkg::LEN_CF-1];
    assign w_ex_dn = (r_trim == AW'(atrlc_pkg::LEN_DNS)) && r_m_dn[atrlc_pkg::LEN_DNS-1];

    // classification in priority order
    logic       r_wifi, r_tcp, n_wifi, n_tcp;
    logic [1:0] w_verdict, w_outcome;
    logic       w_done;

    always_comb begin
        w_verdict = atrlc_pkg::V_NONE;
        n_wifi    = r_wifi;
        n_tcp     = r_tcp;
        w_done    = 1'b0;
        if (r_trim != '0) begin
            if (w_ex_er) begin
                w_verdict = atrlc_pkg::V_ERROR;
            end else if (r_h_wd) begin
                n_wifi    = 1'b0;
                w_verdict = atrlc_pkg::V_CLOSED;
            end else begin
                if (r_h_ip) n_wifi = 1'b1;
                if (r_h_cl) begin
                    n_tcp     = 1'b0;
                    w_verdict = atrlc_pkg::V_CLOSED;
                    w_done    = 1'b1;
                end else if (w_ex_cn) begin
                    n_tcp = 1'b1;
                end else if (w_ex_cf || w_ex_dn) begin
                    n_tcp     = 1'b0;
                    w_verdict = atrlc_pkg::V_ERROR;
                    w_done    = 1'b1;
                end
                if (!w_done) begin
                    if (r_h_ep)      w_verdict = atrlc_pkg::V_ERROR;
                    else if (r_h_op) w_verdict = atrlc_pkg::V_OK;
                end
            end
        end
        case (w_verdict)
            atrlc_pkg::V_OK:     w_outcome = atrlc_pkg::O_SUCCESS;
            atrlc_pkg::V_ERROR:  w_outcome = atrlc_pkg::O_FAILURE;
            atrlc_pkg::V_CLOSED: w_outcome = (r_err_len != 5'd0) ?
                                             atrlc_pkg::O_FAILURE : atrlc_pkg::O_WAIT;
            default:             w_outcome = atrlc_pkg::O_WAIT;
        endcase
        if (r_flush && (w_outcome == atrlc_pkg::O_WAIT)) w_outcome = atrlc_pkg::O_TIMEOUT;
    end

    // link flags and output register
    logic       r_ov;
    logic [1:0] r_verdict, r_outcome;
    logic       r_wifi_o, r_tcp_o;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wifi <= 1'b0;
            r_tcp  <= 1'b0;
            r_ov   <= 1'b0;
        end else if (i_cmd.load) begin
            r_wifi <= n_wifi;
            r_tcp  <= n_tcp;
            r_ov   <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
        if (i_cmd.load) begin
            r_verdict <= w_verdict;
            r_outcome <= w_outcome;
            r_wifi_o  <= n_wifi;
            r_tcp_o   <= n_tcp;
        end
    end

    assign o_out_valid = r_ov;
    assign o_verdict   = r_verdict;
    assign o_outcome   = r_outcome;
    assign o_wifi_up   = r_wifi_o;
    assign o_tcp_up    = r_tcp_o;

    // status to the sequencer
    assign o_status.need_scan = ((i_mode == atrlc_pkg::MODE_BYTE) &&
                                 (i_rx_byte == atrlc_pkg::CH_LF)) ||
                                (i_mode == atrlc_pkg::MODE_FLUSH);
    assign o_status.n_zero    = (r_trim == '0);
    assign o_status.pos_last  = (r_pos == r_trim - AW'(1));
    assign o_status.out_busy  = r_ov && !i_out_ready;

    // checks
    a_trim_le_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_trim <= r_len) else $error("trimmed length beyond line length");
    a_len_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= AW'(LINE_BYTES - 1)) else $error("line length beyond store");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |-> !(r_ov && !i_out_ready)) else $error("result overwritten");
    a_read_in_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_issue |-> (r_pos < r_trim)) else $error("scan read past line end");

endmodule

// File: bench/at_response_line_classifier_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// at_response_line_classifier_test
// Self-checking bench for the modem reply line classifier: directed lines
// for every keyword, pattern and special case, then random reply streams
// under several pattern settings and idle mixes, checked word by word.
// ----------------------------------------------------------------------------
module at_response_line_classifier_test;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int         HOLD_CYCLES = 400;

    typedef struct packed {
        logic [1:0] verdict;
        logic [1:0] outcome;
        logic       wifi;
        logic       tcp;
    } t_line_result;

    // line classifier prediction and pending results
    class line_scoreboard;
        logic [7:0]   line_buf [atrlc_pkg::LINE_BYTES];
        int           line_len;
        logic         wifi_flag, tcp_flag;
        logic [63:0]  ok_lo, ok_hi, err_lo, err_hi;
        logic [4:0]   ok_len, err_len;
        t_line_result pending [$];
        int           errors;
        int           checked;

        function void clear_all();
            line_len = 0; wifi_flag = 0; tcp_flag = 0;
            ok_lo = 0; ok_hi = 0; err_lo = 0; err_hi = 0; ok_len = 0; err_len = 0;
            pending.delete();
            errors = 0; checked = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [63:0] d);
            case (idx)
                atrlc_pkg::REG_OK_LOW:   ok_lo = d;
                atrlc_pkg::REG_OK_HIGH:  ok_hi = d;
                atrlc_pkg::REG_OK_LEN:   ok_len = d[4:0];
                atrlc_pkg::REG_ERR_LOW:  err_lo = d;
                atrlc_pkg::REG_ERR_HIGH: err_hi = d;
                atrlc_pkg::REG_ERR_LEN:  err_len = d[4:0];
                default: ;
            endcase
        endfunction

        // text compare helpers, keyword table has char 0 in bits 7:0
        function bit is_text(int n, logic [127:0] k, int kl);
            if (n != kl) return 0;
            for (int i = 0; i < kl; i++)
                if (line_buf[i] != k[8*i +: 8]) return 0;
            return 1;
        endfunction

        function bit has_text(int n, logic [127:0] k, int kl);
            bit hit;
            if (kl == 0 || kl > n) return 0;
            for (int s = 0; s + kl <= n; s++) begin
                hit = 1;
                for (int i = 0; i < kl; i++)
                    if (line_buf[s+i] != k[8*i +: 8]) hit = 0;
                if (hit) return 1;
            end
            return 0;
        endfunction

        function logic [1:0] line_verdict();
            int n;
            int pl;
            n = line_len;
            while (n > 0 && (line_buf[n-1] == atrlc_pkg::CH_CR ||
                             line_buf[n-1] == atrlc_pkg::CH_LF)) n--;
            if (n == 0) return atrlc_pkg::V_NONE;
            if (is_text(n, atrlc_pkg::K_ERROR, atrlc_pkg::LEN_ERROR))
                return atrlc_pkg::V_ERROR;
            if (has_text(n, atrlc_pkg::K_WD, atrlc_pkg::LEN_WD)) begin
                wifi_flag = 0;
                return atrlc_pkg::V_CLOSED;
            end
            if (has_text(n, atrlc_pkg::K_IP, atrlc_pkg::LEN_IP)) wifi_flag = 1;
            if (has_text(n, atrlc_pkg::K_CL, atrlc_pkg::LEN_CL)) begin
                tcp_flag = 0;
                return atrlc_pkg::V_CLOSED;
            end
            if (is_text(n, atrlc_pkg::K_CN, atrlc_pkg::LEN_CN)) tcp_flag = 1;
            else if (is_text(n, atrlc_pkg::K_CF, atrlc_pkg::LEN_CF) ||
                     is_text(n, atrlc_pkg::K_DNS, atrlc_pkg::LEN_DNS)) begin
                tcp_flag = 0;
                return atrlc_pkg::V_ERROR;
            end
            pl = (err_len > atrlc_pkg::PATTERN_CHARS) ? atrlc_pkg::PATTERN_CHARS : err_len;
            if (has_text(n, {err_hi, err_lo}, pl)) return atrlc_pkg::V_ERROR;
            pl = (ok_len > atrlc_pkg::PATTERN_CHARS) ? atrlc_pkg::PATTERN_CHARS : ok_len;
            if (has_text(n, {ok_hi, ok_lo}, pl)) return atrlc_pkg::V_OK;
            return atrlc_pkg::V_NONE;
        endfunction

        function logic [1:0] outcome_for(logic [1:0] v);
            if (v == atrlc_pkg::V_OK) return atrlc_pkg::O_SUCCESS;
            if (v == atrlc_pkg::V_ERROR) return atrlc_pkg::O_FAILURE;
            if (v == atrlc_pkg::V_CLOSED && err_len != 0) return atrlc_pkg::O_FAILURE;
            return atrlc_pkg::O_WAIT;
        endfunction

        function void note_word(logic [1:0] mode, logic [7:0] b);
            t_line_result r;
            r = '0;
            if (mode == atrlc_pkg::MODE_BYTE) begin
                if (line_len < atrlc_pkg::LINE_BYTES - 1) begin
                    line_buf[line_len] = b;
                    line_len++;
                end
                if (b != atrlc_pkg::CH_LF) return;
                r.verdict = line_verdict();
                r.outcome = outcome_for(r.verdict);
            end else if (mode == atrlc_pkg::MODE_FLUSH) begin
                if (line_len > 0) begin
                    r.verdict = line_verdict();
                    r.outcome = outcome_for(r.verdict);
                end
                if (r.outcome == atrlc_pkg::O_WAIT) r.outcome = atrlc_pkg::O_TIMEOUT;
            end else begin
                if (mode == atrlc_pkg::MODE_CLEAR) line_len = 0;
                return;
            end
            line_len = 0;
            r.wifi = wifi_flag;
            r.tcp = tcp_flag;
            pending.push_back(r);
        endfunction

        function void check_word(t_line_result got);
            t_line_result e;
            checked++;
            if (pending.size() == 0) begin
                $error("result word with nothing pending");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.verdict !== e.verdict) begin
                $error("verdict expected %0d actual %0d", e.verdict, got.verdict);
                errors++;
            end
            if (got.outcome !== e.outcome) begin
                $error("outcome expected %0d actual %0d", e.outcome, got.outcome);
                errors++;
            end
            if (got.wifi !== e.wifi) begin
                $error("wifi_up expected %0d actual %0d", e.wifi, got.wifi);
                errors++;
            end
            if (got.tcp !== e.tcp) begin
                $error("tcp_up expected %0d actual %0d", e.tcp, got.tcp);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk, i_rst_n;
    logic        i_in_valid, o_in_ready;
    logic [1:0]  i_mode;
    logic [7:0]  i_rx_byte;
    logic        o_out_valid, i_out_ready;
    logic [1:0]  o_verdict, o_outcome;
    logic        o_wifi_up, o_tcp_up;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [63:0] i_cfg_data;

    at_response_line_classifier uut (.*);

    line_scoreboard sb;
    int send_idle_pct, recv_idle_pct;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int words_sent;
    longint cycles = 0;
    localparam longint CYCLE_LIMIT = 4000000;

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("at_response_line_classifier regression: fail");
            $finish;
        end
    end

    // receiver side: random stalls plus a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 0;
        end else if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            i_out_ready <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_ready <= 0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_word({o_verdict, o_outcome, o_wifi_up, o_tcp_up});
    end

    // valid stays high across back to back words, drops only on idle and while draining
    task automatic send_word(logic [1:0] mode, logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 0;
            @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_mode <= mode;
        i_rx_byte <= b;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_word(mode, b);
        words_sent++;
    endtask

    task automatic send_text(string s, bit with_crlf);
        for (int i = 0; i < s.len(); i++) send_word(atrlc_pkg::MODE_BYTE, s[i]);
        if (with_crlf) begin
            send_word(atrlc_pkg::MODE_BYTE, atrlc_pkg::CH_CR);
            send_word(atrlc_pkg::MODE_BYTE, atrlc_pkg::CH_LF);
        end
    endtask

    task automatic drain();
        i_in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (atrlc_pkg::LINE_BYTES + 10) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] d);
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
        sb.write_reg(idx, d);
    endtask

    // text to pattern bits, char 0 in bits 7:0
    function automatic logic [127:0] text_bits(string s);
        logic [127:0] r;
        r = '0;
        for (int i = 0; i < 16; i++)
            if (i < s.len()) r[8*i +: 8] = s[i];
        return r;
    endfunction

    task automatic set_patterns(logic [127:0] okp, int okl, logic [127:0] errp, int errl);
        write_reg(atrlc_pkg::REG_OK_LOW, okp[63:0]);
        write_reg(atrlc_pkg::REG_OK_HIGH, okp[127:64]);
        write_reg(atrlc_pkg::REG_OK_LEN, 64'(okl));
        write_reg(atrlc_pkg::REG_ERR_LOW, errp[63:0]);
        write_reg(atrlc_pkg::REG_ERR_HIGH, errp[127:64]);
        write_reg(atrlc_pkg::REG_ERR_LEN, 64'(errl));
        i_cfg_we <= 0;
    endtask

    // random reply line: mostly known replies, some noise and broken lines
    task automatic random_line();
        string pick [12] = '{"OK", "ERROR", "WIFI DISCONNECT", "WIFI GOT IP", "CLOSED",
                             "CONNECT", "CONNECT FAIL", "DNS FAIL", "SEND OK",
                             "+IPD,4:FAIL", "0,CLOSED", "busy p..."};
        int k;
        int r;
        r = $urandom_range(99);
        if (r < 60) begin
            k = $urandom_range(11);
            if ($urandom_range(3) == 0)
                send_word(atrlc_pkg::MODE_BYTE, 8'(8'h41 + $urandom_range(25)));
            send_text(pick[k], 0);
            case ($urandom_range(5))
                0: send_word(atrlc_pkg::MODE_FLUSH, 8'($urandom));
                1: send_word(atrlc_pkg::MODE_BYTE, atrlc_pkg::CH_LF);
                2: send_word(atrlc_pkg::MODE_CLEAR, 8'($urandom));
                default: begin
                    send_word(atrlc_pkg::MODE_BYTE, atrlc_pkg::CH_CR);
                    send_word(atrlc_pkg::MODE_BYTE, atrlc_pkg::CH_LF);
                end
            endcase
        end else if (r < 95) begin
            k = $urandom_range(12);
            for (int i = 0; i < k; i++)
                send_word(($urandom_range(9) == 0) ? MODE_UNUSED : atrlc_pkg::MODE_BYTE,
                          ($urandom_range(3) == 0) ? 8'($urandom) :
                                                     8'(8'h20 + $urandom_range(90)));
            send_word($urandom_range(1) ? atrlc_pkg::MODE_BYTE : atrlc_pkg::MODE_FLUSH,
                      atrlc_pkg::CH_LF);
        end else begin
            // long line, bytes beyond the store dropped
            k = atrlc_pkg::LINE_BYTES - 4 + $urandom_range(12);
            for (int i = 0; i < k; i++)
                send_word(atrlc_pkg::MODE_BYTE,
                          ($urandom_range(15) == 0) ? atrlc_pkg::CH_CR :
                                                      8'(8'h30 + $urandom_range(40)));
            send_word(atrlc_pkg::MODE_BYTE, atrlc_pkg::CH_LF);
        end
    endtask

    initial begin
        sb = new();
        sb.clear_all();
        words_sent = 0;
        send_idle_pct = 19;
        recv_idle_pct = 48;
        i_rst_n = 0;
        i_in_valid = 0;
        i_mode = atrlc_pkg::MODE_BYTE;
        i_rx_byte = 0;
        i_cfg_we = 0;
        i_cfg_index = 0;
        i_cfg_data = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: keywords and special cases with no patterns set
        send_word(atrlc_pkg::MODE_FLUSH, 8'h00);
        send_text("ERROR", 1);
        send_text("WIFI GOT IP", 1);
        send_text("CONNECT", 1);
        send_text("CLOSED", 1);
        send_text("CONNECT FAIL", 1);
        send_text("DNS FAIL", 1);
        send_text("WIFI DISCONNECT", 1);
        send_word(atrlc_pkg::MODE_BYTE, atrlc_pkg::CH_LF);
        send_text("OK", 0);
        send_word(atrlc_pkg::MODE_CLEAR, 8'hFF);
        send_word(MODE_UNUSED, 8'h0A);
        send_text("partial", 0);
        send_word(atrlc_pkg::MODE_FLUSH, 8'hFF);
        send_word(atrlc_pkg::MODE_BYTE, 8'h00);
        send_word(atrlc_pkg::MODE_BYTE, 8'hFF);
        send_word(atrlc_pkg::MODE_BYTE, atrlc_pkg::CH_LF);
        for (int i = 0; i < atrlc_pkg::LINE_BYTES + 5; i++)
            send_word(atrlc_pkg::MODE_BYTE, "x");
        send_word(atrlc_pkg::MODE_BYTE, atrlc_pkg::CH_LF);
        drain();

        // patterns set, lengths below and above the maximum
        set_patterns(text_bits("OK"), 2, text_bits("FAIL"), 4);
        send_text("SEND OK", 1);
        send_text("+FAIL", 1);
        send_text("CLOSED", 1);
        send_text("x", 0);
        send_word(atrlc_pkg::MODE_FLUSH, 8'h00);
        drain();
        set_patterns(text_bits("0123456789ABCDEF"), 31, 128'h5A00, 2);
        send_text("a0123456789ABCDEFb", 1);
        send_word(atrlc_pkg::MODE_BYTE, 8'h00);
        send_text("Z", 1);
        drain();

        // long receiver hold-off while words keep coming
        hold_req <= hold_req + 1;
        for (int i = 0; i < 40; i++) send_text("OK", 1);
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: set_patterns(text_bits("OK"), 2, '0, 0);
                1: set_patterns(text_bits("OK"), 2, text_bits("FAIL"), 4);
                2: set_patterns({$urandom, $urandom, $urandom, $urandom}, 16,
                                {$urandom, $urandom, $urandom, $urandom}, 16);
                3: set_patterns('0, 0, text_bits("ERR"), 3);
                4: set_patterns(text_bits("SEND OK"), 7, text_bits("busy"), 4);
                default: set_patterns(text_bits("A"), 1, '0, 0);
            endcase
            if (phase == 2) begin send_idle_pct = 48; recv_idle_pct = 19; end
            if (phase == 4) begin send_idle_pct = 0; recv_idle_pct = 0; end
            while (words_sent < 190 * (phase + 1) + 300) random_line();
            drain();
        end

        $display("covered %0d words, %0d result words checked, 6 pattern settings",
                 words_sent, sb.checked);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("at_response_line_classifier regression: pass");
        end else begin
            $display("at_response_line_classifier regression: fail");
        end
        $finish;
    end
endmodule
